// ===== hdl/bvu_pkg.sv =====
// Shared types, constants and register indexes for the boids velocity update block.
`default_nettype none

package bvu_pkg;

    localparam int MAX_AGENTS_DEF = 32;

    // Signed dividend width of the shared divider and its unsigned divisor width.
    localparam int DIV_W = 56;
    localparam int DVS_W = 32;
    // Width of the position, velocity and separation sums over the other agents.
    localparam int SUM_W = 40;

    localparam logic [2:0] CFG_AGENT_COUNT   = 3'd0;
    localparam logic [2:0] CFG_CENTER_DIV    = 3'd1;
    localparam logic [2:0] CFG_MATCH_DIV     = 3'd2;
    localparam logic [2:0] CFG_SEP_DIST      = 3'd3;
    localparam logic [2:0] CFG_VEL_LIMIT     = 3'd4;

    localparam logic [5:0]  RST_AGENT_COUNT  = 6'd20;
    localparam logic [10:0] RST_CENTER_DIV   = 11'd100;
    localparam logic [10:0] RST_MATCH_DIV    = 11'd8;
    localparam logic [19:0] RST_SEP_DIST     = 20'd25600;
    localparam logic [19:0] RST_VEL_LIMIT    = 20'd5120;

    typedef logic [2:0][31:0] vec3_t;

    typedef enum logic [1:0] {
        OP_PMEAN,
        OP_VMEAN,
        OP_CENTER,
        OP_MATCH
    } div_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_THR_MUL,
        ST_THR_ACC,
        ST_OWN_RD,
        ST_OWN_LAT,
        ST_NB_RD,
        ST_NB_DATA,
        ST_DSQ_MUL,
        ST_DSQ_ACC,
        ST_CLOSE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SUM,
        ST_SPD_MUL,
        ST_SPD_ACC,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_LIM_MUL,
        ST_LIM_GO,
        ST_LIM_WAIT,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
        logic [DVS_W-1:0]        divisor;
    } div_req_t;

endpackage

`default_nettype wire

// ===== hdl/bvu_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module bvu_div
    import bvu_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire div_req_t                req,
    output logic                         done,
    output logic signed [DIV_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic              run_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  quo_reg;

    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_diff;
    logic              ge;

    assign rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign ge       = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.dividend[DIV_W-1];
            quo_reg <= req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

`default_nettype wire

// ===== hdl/bvu_sqrt.sv =====
// Iterative floor square root of a 64-bit value, one root bit per cycle.
`default_nettype none

module bvu_sqrt
    import bvu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);

    logic        run_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] x_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] rem_diff;
    logic        ge;

    assign rem_sh   = {rem_reg, x_reg[63:62]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign rem_diff = rem_sh - trial;
    assign ge       = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            x_reg    <= {x_reg[61:0], 2'b00};
            rem_reg  <= ge ? rem_diff[33:0] : rem_sh[33:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== hdl/boids_velocity_update.sv =====
// Top level: agent stores, step sequencer, shared multiplier, divider and square root.
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_ready    kind, agent_index, pos_*, vel_*
//  result    out        out_valid / out_ready  result_index, new_vel_*, last
//  config    in         cfg_we                 cfg_index, cfg_data
//
// A load item is written to the stores as it is accepted. In a step of n agents, the
// twelve divisions per agent, and three more when the speed is rescaled, dominate the time.
// After reset the stores hold nothing useful; only loaded slots may be stepped.
// A result waits in the output register; the sequencer stalls only when the next
// result is ready and the previous one has not yet been transferred.
`default_nettype none

module boids_velocity_update
    import bvu_pkg::*;
#(
    parameter int MAX_AGENTS = MAX_AGENTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [4:0]  agent_index,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_y,
    input  wire logic [31:0] pos_z,
    input  wire logic [31:0] vel_x,
    input  wire logic [31:0] vel_y,
    input  wire logic [31:0] vel_z,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       result_index,
    output logic [31:0]      new_vel_x,
    output logic [31:0]      new_vel_y,
    output logic [31:0]      new_vel_z,
    output logic             last,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int CW = $clog2(MAX_AGENTS + 1);

    localparam logic signed [41:0] SAT_MAX = 42'sd2147483647;
    localparam logic signed [41:0] SAT_MIN = -42'sd2147483648;

    // Configuration registers.
    logic [5:0]  cnt_cfg_reg;
    logic [10:0] cd_cfg_reg;
    logic [10:0] md_cfg_reg;
    logic [19:0] sd_cfg_reg;
    logic [19:0] lim_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_cfg_reg <= RST_AGENT_COUNT;
            cd_cfg_reg  <= RST_CENTER_DIV;
            md_cfg_reg  <= RST_MATCH_DIV;
            sd_cfg_reg  <= RST_SEP_DIST;
            lim_cfg_reg <= RST_VEL_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_AGENT_COUNT: cnt_cfg_reg <= cfg_data[5:0];
                CFG_CENTER_DIV:  cd_cfg_reg  <= cfg_data[10:0];
                CFG_MATCH_DIV:   md_cfg_reg  <= cfg_data[10:0];
                CFG_SEP_DIST:    sd_cfg_reg  <= cfg_data;
                CFG_VEL_LIMIT:   lim_cfg_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Agent stores.
    vec3_t          pos_mem [MAX_AGENTS];
    vec3_t          vel_mem [MAX_AGENTS];
    vec3_t          pos_rd_reg;
    vec3_t          vel_rd_reg;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic           pos_we;
    logic           vel_we;
    vec3_t          pos_wdata;
    vec3_t          vel_wdata;

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[wr_addr] <= pos_wdata;
        end
        if (vel_we)
        begin
            vel_mem[wr_addr] <= vel_wdata;
        end
        pos_rd_reg <= pos_mem[rd_addr];
        vel_rd_reg <= vel_mem[rd_addr];
    end

    // Sequencer and datapath registers.
    state_t                  state_reg, state_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           i_reg, i_next;
    logic [CW-1:0]           j_reg, j_next;
    logic [1:0]              c_reg, c_next;
    div_op_t                 op_reg, op_next;
    logic [39:0]             thr2_reg, thr2_next;
    vec3_t                   own_p_reg, own_p_next;
    vec3_t                   own_v_reg, own_v_next;
    logic signed [SUM_W-1:0] ps_reg [3];
    logic signed [SUM_W-1:0] ps_next [3];
    logic signed [SUM_W-1:0] vs_reg [3];
    logic signed [SUM_W-1:0] vs_next [3];
    logic signed [SUM_W-1:0] sep_reg [3];
    logic signed [SUM_W-1:0] sep_next [3];
    logic signed [32:0]      d_reg [3];
    logic signed [32:0]      d_next [3];
    logic [41:0]             d2_reg, d2_next;
    logic signed [33:0]      pm_reg, pm_next;
    logic signed [33:0]      vm_reg, vm_next;
    logic signed [33:0]      t1_reg, t1_next;
    logic signed [33:0]      t2_reg, t2_next;
    logic signed [31:0]      nv_reg [3];
    logic signed [31:0]      nv_next [3];
    logic [63:0]             s2_reg, s2_next;
    logic [31:0]             speed_reg, speed_next;
    logic [63:0]             mul_p_reg;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;

    logic                    out_valid_reg, out_valid_next;
    logic [4:0]              res_idx_reg, res_idx_next;
    logic [31:0]             out_x_reg, out_x_next;
    logic [31:0]             out_y_reg, out_y_next;
    logic [31:0]             out_z_reg, out_z_next;
    logic                    last_reg, last_next;

    div_req_t                div_req;
    logic                    div_done;
    logic signed [DIV_W-1:0] div_q;
    logic                    sqrt_start;
    logic                    sqrt_done;
    logic [31:0]             sqrt_root;

    // Helper signals.
    logic                    in_fire;
    logic                    out_fire;
    logic                    wr_block;
    logic                    j_last;
    logic                    i_last;
    logic                    is_self;
    logic                    is_close;
    logic                    slot_ok;
    logic [CW-1:0]           n_clamp;
    logic signed [32:0]      d_cur [3];
    logic [32:0]             d_mag [3];
    logic                    far;
    logic [32:0]             dsq_mag;
    logic [31:0]             nv_mag;
    logic signed [34:0]      ct_diff;
    logic signed [34:0]      mt_diff;
    logic signed [41:0]      v_sum;
    logic signed [31:0]      v_sat;
    logic [DVS_W-1:0]        nm1;
    logic [DVS_W-1:0]        cd_eff;
    logic [DVS_W-1:0]        md_eff;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign wr_block = out_valid_reg && !out_ready;
    assign j_last   = j_reg == (n_reg - CW'(1));
    assign i_last   = i_reg == (n_reg - CW'(1));
    assign is_self  = j_reg == i_reg;
    assign is_close = d2_reg < {2'b00, thr2_reg};
    assign slot_ok  = int'(agent_index) < MAX_AGENTS;
    assign nm1      = DVS_W'(n_reg - CW'(1));
    assign cd_eff   = (cd_cfg_reg == 11'd0) ? DVS_W'(1) : DVS_W'(cd_cfg_reg);
    assign md_eff   = (md_cfg_reg == 11'd0) ? DVS_W'(1) : DVS_W'(md_cfg_reg);

    always_comb
    begin
        if (int'(cnt_cfg_reg) < 2)
        begin
            n_clamp = CW'(2);
        end
        else if (int'(cnt_cfg_reg) > MAX_AGENTS)
        begin
            n_clamp = CW'(MAX_AGENTS);
        end
        else
        begin
            n_clamp = CW'(cnt_cfg_reg);
        end
    end

    always_comb
    begin
        far = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            d_cur[c] = 33'($signed(own_p_reg[c])) - 33'($signed(pos_rd_reg[c]));
            d_mag[c] = d_cur[c][32] ? 33'(-d_cur[c]) : 33'(d_cur[c]);
            if (d_mag[c][32:20] != 13'd0)
            begin
                far = 1'b1;
            end
        end
    end

    assign dsq_mag = d_reg[c_reg][32] ? 33'(-d_reg[c_reg]) : 33'(d_reg[c_reg]);
    assign nv_mag  = 32'(33'sd0 - 33'(nv_reg[c_reg]));
    assign ct_diff = 35'(pm_reg) - 35'($signed(own_p_reg[c_reg]));
    assign mt_diff = 35'(vm_reg) - 35'($signed(own_v_reg[c_reg]));
    assign v_sum   = 42'($signed(own_v_reg[c_reg])) + 42'(t1_reg) + 42'(t2_reg)
                   + 42'(sep_reg[c_reg]);

    always_comb
    begin
        if (v_sum > SAT_MAX)
        begin
            v_sat = 32'sh7FFFFFFF;
        end
        else if (v_sum < SAT_MIN)
        begin
            v_sat = 32'sh80000000;
        end
        else
        begin
            v_sat = 32'(v_sum);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && kind)
                begin
                    state_next = ST_THR_MUL;
                end
            end
            ST_THR_MUL:   state_next = ST_THR_ACC;
            ST_THR_ACC:   state_next = ST_OWN_RD;
            ST_OWN_RD:    state_next = ST_OWN_LAT;
            ST_OWN_LAT:   state_next = ST_NB_RD;
            ST_NB_RD:     state_next = ST_NB_DATA;
            ST_NB_DATA:
            begin
                if (is_self || far)
                begin
                    state_next = j_last ? ST_DIV_GO : ST_NB_RD;
                end
                else
                begin
                    state_next = ST_DSQ_MUL;
                end
            end
            ST_DSQ_MUL:   state_next = ST_DSQ_ACC;
            ST_DSQ_ACC:   state_next = (c_reg == 2'd2) ? ST_CLOSE : ST_DSQ_MUL;
            ST_CLOSE:     state_next = j_last ? ST_DIV_GO : ST_NB_RD;
            ST_DIV_GO:    state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (op_reg == OP_MATCH) ? ST_SUM : ST_DIV_GO;
                end
            end
            ST_SUM:       state_next = (c_reg == 2'd2) ? ST_SPD_MUL : ST_DIV_GO;
            ST_SPD_MUL:   state_next = ST_SPD_ACC;
            ST_SPD_ACC:   state_next = (c_reg == 2'd2) ? ST_SQRT_GO : ST_SPD_MUL;
            ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    state_next = (sqrt_root > 32'(lim_cfg_reg)) ? ST_LIM_MUL : ST_WRITE;
                end
            end
            ST_LIM_MUL:   state_next = ST_LIM_GO;
            ST_LIM_GO:    state_next = ST_LIM_WAIT;
            ST_LIM_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (c_reg == 2'd2) ? ST_WRITE : ST_LIM_MUL;
                end
            end
            ST_WRITE:
            begin
                if (!wr_block)
                begin
                    state_next = i_last ? ST_IDLE : ST_OWN_RD;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and control outputs.
    always_comb
    begin
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        c_next         = c_reg;
        op_next        = op_reg;
        thr2_next      = thr2_reg;
        own_p_next     = own_p_reg;
        own_v_next     = own_v_reg;
        d2_next        = d2_reg;
        pm_next        = pm_reg;
        vm_next        = vm_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        s2_next        = s2_reg;
        speed_next     = speed_reg;
        for (int c = 0; c < 3; c++)
        begin
            ps_next[c]  = ps_reg[c];
            vs_next[c]  = vs_reg[c];
            sep_next[c] = sep_reg[c];
            d_next[c]   = d_reg[c];
            nv_next[c]  = nv_reg[c];
        end
        out_valid_next = out_fire ? 1'b0 : out_valid_reg;
        res_idx_next   = res_idx_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        last_next      = last_reg;
        in_ready       = 1'b0;
        rd_addr        = j_reg[AW-1:0];
        wr_addr        = i_reg[AW-1:0];
        pos_we         = 1'b0;
        vel_we         = 1'b0;
        pos_wdata      = {pos_z, pos_y, pos_x};
        vel_wdata      = {vel_z, vel_y, vel_x};
        mul_a          = '0;
        mul_b          = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = DVS_W'(1);
        sqrt_start     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    if (kind)
                    begin
                        n_next = n_clamp;
                        i_next = '0;
                    end
                    else if (slot_ok)
                    begin
                        wr_addr = AW'(agent_index);
                        pos_we  = 1'b1;
                        vel_we  = 1'b1;
                    end
                end
            end
            ST_THR_MUL:
            begin
                mul_a = 32'(sd_cfg_reg);
                mul_b = 32'(sd_cfg_reg);
            end
            ST_THR_ACC:
            begin
                thr2_next = mul_p_reg[39:0];
            end
            ST_OWN_RD:
            begin
                rd_addr = i_reg[AW-1:0];
            end
            ST_OWN_LAT:
            begin
                own_p_next = pos_rd_reg;
                own_v_next = vel_rd_reg;
                j_next     = '0;
                for (int c = 0; c < 3; c++)
                begin
                    ps_next[c]  = '0;
                    vs_next[c]  = '0;
                    sep_next[c] = '0;
                end
            end
            ST_NB_DATA:
            begin
                if (!is_self)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        ps_next[c] = ps_reg[c] + SUM_W'($signed(pos_rd_reg[c]));
                        vs_next[c] = vs_reg[c] + SUM_W'($signed(vel_rd_reg[c]));
                        d_next[c]  = d_cur[c];
                    end
                end
                c_next  = '0;
                d2_next = '0;
                if (is_self || far)
                begin
                    j_next  = j_reg + CW'(1);
                    op_next = OP_PMEAN;
                end
            end
            ST_DSQ_MUL:
            begin
                mul_a = 32'(dsq_mag[19:0]);
                mul_b = 32'(dsq_mag[19:0]);
            end
            ST_DSQ_ACC:
            begin
                d2_next = d2_reg + 42'(mul_p_reg[39:0]);
                c_next  = c_reg + 2'd1;
            end
            ST_CLOSE:
            begin
                if (is_close)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        sep_next[c] = sep_reg[c] + SUM_W'(d_reg[c]);
                    end
                end
                j_next  = j_reg + CW'(1);
                c_next  = '0;
                op_next = OP_PMEAN;
            end
            ST_DIV_GO:
            begin
                div_req.start = 1'b1;
                case (op_reg)
                    OP_PMEAN:
                    begin
                        div_req.dividend = DIV_W'(ps_reg[c_reg]);
                        div_req.divisor  = nm1;
                    end
                    OP_VMEAN:
                    begin
                        div_req.dividend = DIV_W'(vs_reg[c_reg]);
                        div_req.divisor  = nm1;
                    end
                    OP_CENTER:
                    begin
                        div_req.dividend = DIV_W'(ct_diff);
                        div_req.divisor  = cd_eff;
                    end
                    OP_MATCH:
                    begin
                        div_req.dividend = DIV_W'(mt_diff);
                        div_req.divisor  = md_eff;
                    end
                    default:
                    begin
                        div_req.dividend = '0;
                        div_req.divisor  = DVS_W'(1);
                    end
                endcase
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (op_reg)
                        OP_PMEAN:  pm_next = div_q[33:0];
                        OP_VMEAN:  vm_next = div_q[33:0];
                        OP_CENTER: t1_next = div_q[33:0];
                        OP_MATCH:  t2_next = div_q[33:0];
                        default:   ;
                    endcase
                    op_next = div_op_t'(op_reg + 2'd1);
                end
            end
            ST_SUM:
            begin
                nv_next[c_reg] = v_sat;
                op_next        = OP_PMEAN;
                s2_next        = '0;
                c_next         = (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
            end
            ST_SPD_MUL:
            begin
                mul_a = nv_reg[c_reg][31] ? nv_mag : 32'(nv_reg[c_reg]);
                mul_b = nv_reg[c_reg][31] ? nv_mag : 32'(nv_reg[c_reg]);
            end
            ST_SPD_ACC:
            begin
                s2_next = s2_reg + mul_p_reg;
                c_next  = (c_reg == 2'd2) ? 2'd0 : c_reg + 2'd1;
            end
            ST_SQRT_GO:
            begin
                sqrt_start = 1'b1;
            end
            ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    speed_next = sqrt_root;
                end
                c_next = '0;
            end
            ST_LIM_MUL:
            begin
                mul_a = nv_reg[c_reg][31] ? nv_mag : 32'(nv_reg[c_reg]);
                mul_b = 32'(lim_cfg_reg);
            end
            ST_LIM_GO:
            begin
                // The product is a magnitude; the sign of the velocity goes back on here.
                div_req.start    = 1'b1;
                div_req.dividend = nv_reg[c_reg][31] ? -$signed(DIV_W'(mul_p_reg))
                                                     : $signed(DIV_W'(mul_p_reg));
                div_req.divisor  = speed_reg;
            end
            ST_LIM_WAIT:
            begin
                if (div_done)
                begin
                    nv_next[c_reg] = div_q[31:0];
                    c_next         = c_reg + 2'd1;
                end
            end
            ST_WRITE:
            begin
                vel_wdata = {nv_reg[2], nv_reg[1], nv_reg[0]};
                if (!wr_block)
                begin
                    vel_we         = 1'b1;
                    out_valid_next = 1'b1;
                    res_idx_next   = 5'(i_reg);
                    out_x_next     = nv_reg[0];
                    out_y_next     = nv_reg[1];
                    out_z_next     = nv_reg[2];
                    last_next      = i_last;
                    i_next         = i_reg + CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= CW'(2);
            i_reg         <= '0;
            j_reg         <= '0;
            c_reg         <= '0;
            op_reg        <= OP_PMEAN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            c_reg         <= c_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        thr2_reg    <= thr2_next;
        own_p_reg   <= own_p_next;
        own_v_reg   <= own_v_next;
        d2_reg      <= d2_next;
        pm_reg      <= pm_next;
        vm_reg      <= vm_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        s2_reg      <= s2_next;
        speed_reg   <= speed_next;
        for (int c = 0; c < 3; c++)
        begin
            ps_reg[c]  <= ps_next[c];
            vs_reg[c]  <= vs_next[c];
            sep_reg[c] <= sep_next[c];
            d_reg[c]   <= d_next[c];
            nv_reg[c]  <= nv_next[c];
        end
        mul_p_reg   <= 64'(mul_a) * 64'(mul_b);
        res_idx_reg <= res_idx_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_z_reg   <= out_z_next;
        last_reg    <= last_next;
    end

    bvu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    bvu_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (s2_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign out_valid    = out_valid_reg;
    assign result_index = res_idx_reg;
    assign new_vel_x    = out_x_reg;
    assign new_vel_y    = out_y_reg;
    assign new_vel_z    = out_z_reg;
    assign last         = last_reg;

    // The rescale divides by the speed, which must exceed the limit and so is nonzero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIM_GO) |-> (speed_reg > 32'(lim_cfg_reg)))
        else $error("rescale started with speed not above the limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NB_DATA) |-> (j_reg < n_reg && i_reg < n_reg))
        else $error("neighbor walk outside the active agents");

    assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == ST_SQRT_WAIT))
        else $error("square root finished outside its wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && !wr_block) |=> out_valid_reg)
        else $error("agent result not presented after its write");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the boids velocity update block.
`default_nettype none

module tb;
    import bvu_pkg::*;

    localparam int  MAX_SLOTS   = 32;
    localparam int  CYCLE_LIMIT = 20000000;
    localparam int  SETTLE      = 40;
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef struct {
        logic [4:0]  idx;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        lst;
    } velocity_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [4:0]  agent_index = '0;
    logic [31:0] pos_x = '0;
    logic [31:0] pos_y = '0;
    logic [31:0] pos_z = '0;
    logic [31:0] vel_x = '0;
    logic [31:0] vel_y = '0;
    logic [31:0] vel_z = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  result_index;
    logic [31:0] new_vel_x;
    logic [31:0] new_vel_y;
    logic [31:0] new_vel_z;
    logic        last;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;

    // Predictor state: the agent stores and the register file.
    longint      flock_pos[MAX_SLOTS][3];
    longint      flock_vel[MAX_SLOTS][3];
    logic [5:0]  reg_agent_count = RST_AGENT_COUNT;
    logic [10:0] reg_center_div  = RST_CENTER_DIV;
    logic [10:0] reg_match_div   = RST_MATCH_DIV;
    logic [19:0] reg_sep_dist    = RST_SEP_DIST;
    logic [19:0] reg_vel_limit   = RST_VEL_LIMIT;

    velocity_result_t pending_velocities[$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;
    int  hold_request = 0;
    int  hold_left = 0;

    boids_velocity_update i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .agent_index(agent_index),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_index(result_index),
        .new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .new_vel_z(new_vel_z),
        .last(last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit neighbour_close(int self_i, int other_j);
        longint unsigned thr;
        longint unsigned d2;
        longint unsigned m;
        thr = reg_sep_dist;
        d2 = 0;
        for (int c = 0; c < 3; c++)
        begin
            m = magnitude(flock_pos[other_j][c] - flock_pos[self_i][c]);
            if (m >= (64'd1 << 20))
                return 1'b0;
            d2 += m * m;
        end
        return d2 < thr * thr;
    endfunction

    // Updates the velocities of the first n agents in place, in index order, and queues one result per agent.
    function automatic void predict_flock_step();
        int      n;
        longint  cd;
        longint  md;
        longint  ps[3];
        longint  vs[3];
        longint  sep[3];
        longint  nv[3];
        longint  v;
        longint unsigned s2;
        longint unsigned speed;
        velocity_result_t r;
        n = reg_agent_count;
        if (n < 2) n = 2;
        if (n > MAX_SLOTS) n = MAX_SLOTS;
        cd = (reg_center_div == 0) ? 1 : reg_center_div;
        md = (reg_match_div == 0) ? 1 : reg_match_div;
        for (int i = 0; i < n; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ps[c] = 0;
                vs[c] = 0;
                sep[c] = 0;
            end
            for (int j = 0; j < n; j++)
            begin
                if (j != i)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        ps[c] += flock_pos[j][c];
                        vs[c] += flock_vel[j][c];
                    end
                    if (neighbour_close(i, j))
                        for (int c = 0; c < 3; c++)
                            sep[c] += flock_pos[i][c] - flock_pos[j][c];
                end
            end
            s2 = 0;
            for (int c = 0; c < 3; c++)
            begin
                v = flock_vel[i][c];
                v += (ps[c] / (n - 1) - flock_pos[i][c]) / cd;
                v += (vs[c] / (n - 1) - flock_vel[i][c]) / md;
                v += sep[c];
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                nv[c] = v;
                s2 += magnitude(v) * magnitude(v);
            end
            speed = floor_sqrt(s2);
            if (speed > reg_vel_limit)
                for (int c = 0; c < 3; c++)
                    nv[c] = (nv[c] * longint'(reg_vel_limit)) / longint'(speed);
            for (int c = 0; c < 3; c++)
                flock_vel[i][c] = nv[c];
            r.idx = i[4:0];
            r.vx = nv[0][31:0];
            r.vy = nv[1][31:0];
            r.vz = nv[2][31:0];
            r.lst = (i == n - 1);
            pending_velocities.push_back(r);
        end
    endfunction

    // Receiver: random stalls, an optional long hold-off, and steady stretches.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rx_steady || ($urandom_range(99) >= 28);
    end

    always @(posedge clk)
    begin
        velocity_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_velocities.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result for agent %0d", $time, result_index);
            end
            else
            begin
                e = pending_velocities.pop_front();
                if (result_index !== e.idx || new_vel_x !== e.vx || new_vel_y !== e.vy ||
                    new_vel_z !== e.vz || last !== e.lst)
                begin
                    mismatches++;
                    $display("%0t: mismatch expected idx=%0d v=(%h %h %h) last=%b",
                             $time, e.idx, e.vx, e.vy, e.vz, e.lst);
                    $display("%0t:          actual   idx=%0d v=(%h %h %h) last=%b",
                             $time, result_index, new_vel_x, new_vel_y, new_vel_z, last);
                end
            end
        end
    end

    // Offers one item and returns at the edge where it transfers; valid stays high.
    task automatic send_item(input logic k, input logic [4:0] idx,
                             input vec3_t p, input vec3_t v);
        while (!tx_steady && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        agent_index <= idx;
        pos_x <= p[0];
        pos_y <= p[1];
        pos_z <= p[2];
        vel_x <= v[0];
        vel_y <= v[1];
        vel_z <= v[2];
        do
            @(posedge clk);
        while (!in_ready);
        if (k == KIND_LOAD)
        begin
            for (int c = 0; c < 3; c++)
            begin
                flock_pos[idx][c] = $signed(p[c]);
                flock_vel[idx][c] = $signed(v[c]);
            end
        end
        else
            predict_flock_step();
    endtask

    task automatic load_agent(input logic [4:0] idx, input vec3_t p, input vec3_t v);
        send_item(KIND_LOAD, idx, p, v);
    endtask

    task automatic run_step();
        vec3_t junk_p;
        vec3_t junk_v;
        junk_p = {$urandom, $urandom, $urandom};
        junk_v = {$urandom, $urandom, $urandom};
        send_item(KIND_STEP, 5'($urandom), junk_p, junk_v);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_velocities.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_AGENT_COUNT: reg_agent_count = data[5:0];
            CFG_CENTER_DIV:  reg_center_div  = data[10:0];
            CFG_MATCH_DIV:   reg_match_div   = data[10:0];
            CFG_SEP_DIST:    reg_sep_dist    = data;
            CFG_VEL_LIMIT:   reg_vel_limit   = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [5:0] n, input logic [10:0] cdiv,
                             input logic [10:0] mdiv, input logic [19:0] sep,
                             input logic [19:0] lim);
        write_reg(CFG_AGENT_COUNT, 20'(n));
        write_reg(CFG_CENTER_DIV, 20'(cdiv));
        write_reg(CFG_MATCH_DIV, 20'(mdiv));
        write_reg(CFG_SEP_DIST, sep);
        write_reg(CFG_VEL_LIMIT, lim);
    endtask

    // A coordinate near base; now and then a fully random one.
    function automatic logic [31:0] near(input logic [31:0] base, input int spread);
        if ($urandom_range(99) < 8)
            return $urandom;
        return base + 32'($urandom_range(0, 2 * spread)) - 32'(spread);
    endfunction

    task automatic load_cluster(input int first, input int count, input int spread);
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        vec3_t p;
        vec3_t v;
        cx = $urandom;
        cy = $urandom;
        cz = $urandom;
        for (int a = first; a < first + count; a++)
        begin
            p = {near(cz, spread), near(cy, spread), near(cx, spread)};
            v = {near(32'd0, 8000), near(32'd0, 8000), near(32'd0, 8000)};
            load_agent(a[4:0], p, v);
        end
    endtask

    task automatic test_reset_settings();
        load_cluster(0, MAX_SLOTS, 20000);
        run_step();
        wait_all_results();
    endtask

    task automatic test_register_extremes();
        // Agent count below the minimum acts as two; zero divisors act as one.
        configure(6'd0, 11'd0, 11'd0, 20'hFFFFF, 20'd0);
        load_agent(5'd0, {32'h7FFFFFFF, 32'h80000000, 32'h0}, {32'h7FFFFFFF, 32'h80000000,
                   32'hFFFFFFFF});
        load_agent(5'd1, {32'h7FFFFFFF, 32'h80000000, 32'h0}, {32'h80000000, 32'h7FFFFFFF,
                   32'h1});
        run_step();
        wait_all_results();
        configure(6'd1, 11'd2047, 11'd2047, 20'hFFFFF, 20'hFFFFF);
        load_agent(5'd0, {32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF},
                   {32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
        load_agent(5'd1, {32'h7FF10000, 32'h7FF10000, 32'h7FF10000},
                   {32'h80000000, 32'h80000000, 32'h80000000});
        run_step();
        wait_all_results();
        // Agent count above the store depth is taken as the full store.
        configure(6'd63, 11'd1, 11'd1, 20'd0, 20'd1);
        load_cluster(0, 4, 3000);
        load_agent(5'd31, {32'h80000000, 32'h0, 32'h7FFFFFFF}, {32'h0, 32'h0, 32'h0});
        run_step();
        wait_all_results();
        configure(6'd32, 11'd1024, 11'd1, 20'd100000, 20'd0);
        run_step();
        wait_all_results();
    endtask

    task automatic test_output_backpressure();
        configure(6'd2, 11'd16, 11'd4, 20'd4000, 20'd3000);
        load_cluster(0, 2, 2000);
        hold_request = 6000;
        run_step();
        load_cluster(2, 4, 2000);
        run_step();
        load_cluster(0, 3, 2000);
        wait_all_results();
    endtask

    task automatic test_random_flocks();
        int items;
        int n;
        int extra;
        items = 0;
        while (items < 245)
        begin
            tx_steady = (items < 60);
            rx_steady = (items < 60);
            n = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(2, 5);
            configure(6'(n), 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                      20'($urandom_range(0, 1 << ($urandom_range(8, 20)))),
                      ($urandom_range(3) == 0) ? 20'($urandom) :
                                                 20'($urandom_range(0, 20000)));
            extra = $urandom_range(2, 8);
            load_cluster($urandom_range(0, 12), extra, $urandom_range(500, 60000));
            load_cluster(0, n, $urandom_range(500, 60000));
            run_step();
            if ($urandom_range(2) == 0)
            begin
                load_cluster(0, 2, 3000);
                run_step();
                items += 3;
            end
            items += n + extra + 1;
            wait_all_results();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings();
        test_register_extremes();
        test_output_backpressure();
        test_random_flocks();
        wait_all_results();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/bvu_pkg.sv
hdl/bvu_div.sv
hdl/bvu_sqrt.sv
hdl/boids_velocity_update.sv
tb/sv/tb.sv
